[src/ple_pkg.sv]
// Shared types, codes and defaults for the positional list engine.
package ple_pkg;

	localparam int DefCapacity = 128;

	typedef enum logic [1:0] {
		FN_READ   = 2'd0,
		FN_SEARCH = 2'd1,
		FN_INSERT = 2'd2,
		FN_REMOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		SC_OK       = 2'd0,
		SC_BAD      = 2'd1,
		SC_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RWAIT,
		ST_SRCH,
		ST_ISHIFT,
		ST_IPUT,
		ST_RTAKE,
		ST_RSHIFT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_POS,
		RD_LAST,
		RD_ZERO,
		RD_NEXT,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_APPEND,
		WR_UP,
		WR_PUT,
		WR_DOWN
	} wr_sel_t;

	typedef struct packed {
		logic    req_ld;
		rd_sel_t rd_sel;
		logic    cur_ld;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    status_ld;
		status_t status;
		logic    data_ld;
		logic    fpos_ld;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_ld;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  bad_read;
		logic  bad_ins;
		logic  append;
		logic  empty;
		logic  match;
		logic  last;
		logic  at_pos;
		logic  out_free;
	} dp_stat_t;

endpackage

[src/ple_ctrl.sv]
// Sequencer for the positional list engine: steps each request through the store.
module ple_ctrl
	import ple_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.req_ld = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				unique case (stat.func)
					FN_READ: begin
						if (stat.bad_read) begin
							cmd.status_ld = 1'b1;
							cmd.status    = SC_BAD;
							state_d       = ST_DONE;
						end else begin
							cmd.rd_sel = RD_POS;
							state_d    = ST_RWAIT;
						end
					end
					FN_SEARCH: begin
						if (stat.empty) begin
							cmd.status_ld = 1'b1;
							cmd.status    = SC_NOTFOUND;
							state_d       = ST_DONE;
						end else begin
							cmd.rd_sel = RD_ZERO;
							cmd.cur_ld = 1'b1;
							state_d    = ST_SRCH;
						end
					end
					FN_INSERT: begin
						if (stat.bad_ins) begin
							cmd.status_ld = 1'b1;
							cmd.status    = SC_BAD;
							state_d       = ST_DONE;
						end else if (stat.append) begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WR_APPEND;
							cmd.cnt_inc = 1'b1;
							state_d     = ST_DONE;
						end else begin
							cmd.rd_sel = RD_LAST;
							cmd.cur_ld = 1'b1;
							state_d    = ST_ISHIFT;
						end
					end
					FN_REMOVE: begin
						if (stat.bad_read) begin
							cmd.status_ld = 1'b1;
							cmd.status    = SC_BAD;
							state_d       = ST_DONE;
						end else begin
							cmd.rd_sel = RD_POS;
							cmd.cur_ld = 1'b1;
							state_d    = ST_RTAKE;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_RWAIT: begin
				cmd.data_ld = 1'b1;
				state_d     = ST_DONE;
			end
			ST_SRCH: begin
				if (stat.match) begin
					cmd.fpos_ld = 1'b1;
					state_d     = ST_DONE;
				end else if (stat.last) begin
					cmd.status_ld = 1'b1;
					cmd.status    = SC_NOTFOUND;
					state_d       = ST_DONE;
				end else begin
					cmd.rd_sel = RD_NEXT;
					cmd.cur_ld = 1'b1;
				end
			end
			ST_ISHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_UP;
				if (stat.at_pos) begin
					state_d = ST_IPUT;
				end else begin
					cmd.rd_sel = RD_PREV;
					cmd.cur_ld = 1'b1;
				end
			end
			ST_IPUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_PUT;
				cmd.cnt_inc = 1'b1;
				state_d     = ST_DONE;
			end
			ST_RTAKE: begin
				cmd.data_ld = 1'b1;
				if (stat.last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_sel = RD_NEXT;
					cmd.cur_ld = 1'b1;
					state_d    = ST_RSHIFT;
				end
			end
			ST_RSHIFT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_DOWN;
				if (stat.last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_sel = RD_NEXT;
					cmd.cur_ld = 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[src/ple_datapath.sv]
// Datapath: entry store, count, walk index, result and output word register.
module ple_datapath
	import ple_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
)(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     func,
	input  logic [7:0]     position,
	input  logic [31:0]    value,
	input  dp_cmd_t        cmd,
	output dp_stat_t       stat,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [55:0]    m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = ((CW > 8) ? CW : 8) + 1;

	logic [31:0]   entries [CAPACITY];
	logic [31:0]   rdata_q;
	logic [AW-1:0] rd_addr, wr_addr, cur_q, pos_idx;
	logic [31:0]   wr_data;

	func_t         func_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [CW-1:0] cnt_q;
	status_t       res_status_q;
	logic [31:0]   res_data_q;
	logic [7:0]    res_fpos_q;
	logic          out_valid_q;
	logic [55:0]   out_word_q;

	logic [EW-1:0] pos_e, cnt_e, cur_e;
	logic          full;

	assign pos_e   = EW'(pos_q);
	assign cnt_e   = EW'(cnt_q);
	assign cur_e   = EW'(cur_q);
	assign pos_idx = AW'(pos_e - EW'(1));
	assign full    = (cnt_e == EW'(CAPACITY));

	always_comb begin
		stat.func     = func_q;
		stat.bad_read = (pos_q == 8'd0) || (pos_e > cnt_e);
		stat.bad_ins  = full || (pos_q == 8'd0) || (pos_e > cnt_e + EW'(1));
		stat.append   = (pos_e == cnt_e + EW'(1));
		stat.empty    = (cnt_q == '0);
		stat.match    = (rdata_q == val_q);
		stat.last     = (cur_e + EW'(1) == cnt_e);
		stat.at_pos   = (cur_q == pos_idx);
		stat.out_free = !out_valid_q || m_tready;
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_POS:  rd_addr = pos_idx;
			RD_LAST: rd_addr = AW'(cnt_e - EW'(1));
			RD_ZERO: rd_addr = '0;
			RD_NEXT: rd_addr = cur_q + AW'(1);
			RD_PREV: rd_addr = cur_q - AW'(1);
			default: rd_addr = '0;
		endcase
		case (cmd.wr_sel)
			WR_APPEND: begin
				wr_addr = AW'(cnt_q);
				wr_data = val_q;
			end
			WR_UP: begin
				wr_addr = cur_q + AW'(1);
				wr_data = rdata_q;
			end
			WR_PUT: begin
				wr_addr = pos_idx;
				wr_data = val_q;
			end
			default: begin
				wr_addr = cur_q - AW'(1);
				wr_data = rdata_q;
			end
		endcase
	end

	// single-port style store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			entries[wr_addr] <= wr_data;
		end
		rdata_q <= entries[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.req_ld) begin
			func_q <= func_t'(func);
			pos_q  <= position;
			val_q  <= value;
		end
		if (cmd.cur_ld) begin
			cur_q <= rd_addr;
		end
		if (cmd.req_ld) begin
			res_status_q <= SC_OK;
			res_data_q   <= '0;
			res_fpos_q   <= '0;
		end else begin
			if (cmd.status_ld) begin
				res_status_q <= cmd.status;
			end
			if (cmd.data_ld) begin
				res_data_q <= rdata_q;
			end
			if (cmd.fpos_ld) begin
				res_fpos_q <= 8'((cur_e + EW'(1)) & EW'(8'hFF));
			end
		end
		if (cmd.out_ld) begin
			out_word_q <= {4'd0, full, (cnt_q == '0), cnt_e[7:0], res_fpos_q,
				res_data_q, res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;

endmodule

[src/positional_list_engine.sv]
// Top level of the positional list engine: stream ports, sequencer and datapath.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a single store
// that gives one write and one registered read per cycle; that port sets the
// timing. A read at position p waits for the registered read of entry p; a search
// compares entries from the first until a match or the last entry; an insert at p
// moves the entries from the last down to p up by one, then writes the value at p
// (an append writes it at the end at once); a remove takes entry p and moves each
// later entry down by one. A request with a bad position or into a full list, or
// a search of an empty list, goes straight to the output register, which holds
// the result while the downstream side stalls. A new request is taken once the
// previous one has reached the output register, in the cycle after at the
// earliest. There is no clearing pass after reset: entries at or beyond the
// count are never read. Count and found position are reported modulo 256.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // func[1:0], position[9:2], value[41:10], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // status[1:0], data_out[33:2], found_position[41:34],
	                              // count[49:42], is_empty[50], is_full[51], zero pad
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ple_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.func     (s_tdata[1:0]),
		.position (s_tdata[9:2]),
		.value    (s_tdata[41:10]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// one request in flight: ready drops straight after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in progress");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == SC_BAD) |-> (m_tdata[41:2] == '0))
		else $error("error result carries data or position");

	a_notfound_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == SC_NOTFOUND) |-> (m_tdata[41:2] == '0))
		else $error("not-found result carries data or position");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[50] && m_tdata[51]) && (m_tdata[1:0] != 2'd3))
		else $error("inconsistent flags or status in result word");

endmodule
